FILE: rtl/omrq_pkg.sv
package omrq_pkg;

    localparam int QUEUE_SLOTS = 16;
    localparam int SLOT_BYTES  = 64;

    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 5;
    localparam int LEN_W    = 6;
    localparam int BSIZE_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int MEM_DEPTH = QUEUE_SLOTS * SLOT_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = RES_AW + 1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_DEQ  = 1'b1;

    localparam logic CFG_SLOTS = 1'b0;
    localparam logic CFG_BYTES = 1'b1;

    typedef enum logic [1:0] {
        KIND_STORED = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_EMPTY  = 2'd2,
        KIND_BUSY   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_SINGLE = 2'd1,
        RES_STREAM = 2'd2
    } res_op_t;

    typedef struct packed {
        logic              wr_en;
        logic [MEM_AW-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        res_op_t           op;
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic [CNT_W-1:0]  entries;
    } cmd_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] data;
        logic              data_valid;
        logic              last;
        logic [CNT_W-1:0]  entries;
    } res_t;

    function automatic logic [MEM_AW-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [LEN_W-1:0] idx);
        logic [MEM_AW-1:0] base;
        base = MEM_AW'(MEM_AW'(slot) * MEM_AW'(SLOT_BYTES));
        return MEM_AW'(base + MEM_AW'(idx));
    endfunction

endpackage

FILE: rtl/omrq_front.sv
module omrq_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           operation,
    input  logic [omrq_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           byte_valid,
    input  logic                           last_byte,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [omrq_pkg::BSIZE_W-1:0]   cfg_data,
    output logic                           cmd_valid,
    output omrq_pkg::cmd_t                 cmd,
    input  logic                           cmd_ready
);

    logic [omrq_pkg::CNT_W-1:0]   slots_reg, slots_next;
    logic [omrq_pkg::BSIZE_W-1:0] bsize_reg, bsize_next;
    logic [omrq_pkg::SLOT_W-1:0]  ws_reg, ws_next;
    logic [omrq_pkg::SLOT_W-1:0]  rs_reg, rs_next;
    logic                         wrap_reg, wrap_next;
    logic [omrq_pkg::LEN_W-1:0]   open_len_reg, open_len_next;
    logic                         open_reg, open_next;
    logic [omrq_pkg::LEN_W-1:0]   lengths_reg [omrq_pkg::QUEUE_SLOTS];

    logic                         len_we;
    logic [omrq_pkg::LEN_W-1:0]   len_wdata;
    logic [omrq_pkg::CNT_W-1:0]   ring_n;
    logic [omrq_pkg::BSIZE_W-1:0] cap;
    logic                         accept;
    logic [omrq_pkg::SLOT_W-1:0]  head;
    logic [omrq_pkg::LEN_W-1:0]   head_len;

    function automatic logic [omrq_pkg::SLOT_W-1:0] ring_inc(
        input logic [omrq_pkg::SLOT_W-1:0] p,
        input logic [omrq_pkg::CNT_W-1:0]  n
    );
        logic [omrq_pkg::CNT_W-1:0] t;
        t = omrq_pkg::CNT_W'({1'b0, p}) + 1'b1;
        return (t == n) ? '0 : t[omrq_pkg::SLOT_W-1:0];
    endfunction

    function automatic logic [omrq_pkg::CNT_W-1:0] ring_count(
        input logic [omrq_pkg::SLOT_W-1:0] w,
        input logic [omrq_pkg::SLOT_W-1:0] r,
        input logic                        wrap,
        input logic [omrq_pkg::CNT_W-1:0]  n
    );
        logic [omrq_pkg::CNT_W-1:0] d;
        if (w >= r)
        begin
            d = omrq_pkg::CNT_W'({1'b0, w}) - omrq_pkg::CNT_W'({1'b0, r});
        end
        else
        begin
            d = omrq_pkg::CNT_W'({1'b0, w}) + n - omrq_pkg::CNT_W'({1'b0, r});
        end
        if (wrap)
        begin
            d = d + 1'b1;
        end
        return d;
    endfunction

    assign ring_n = (slots_reg == '0) ? omrq_pkg::CNT_W'(1) :
                    (slots_reg > omrq_pkg::CNT_W'(omrq_pkg::QUEUE_SLOTS)) ?
                    omrq_pkg::CNT_W'(omrq_pkg::QUEUE_SLOTS) : slots_reg;
    assign cap = ((bsize_reg == '0) ? omrq_pkg::BSIZE_W'(1) :
                  (bsize_reg > omrq_pkg::BSIZE_W'(omrq_pkg::SLOT_BYTES)) ?
                  omrq_pkg::BSIZE_W'(omrq_pkg::SLOT_BYTES) : bsize_reg) - 1'b1;

    assign full   = !cmd_ready;
    assign accept = push && cmd_ready;
    assign head   = !wrap_reg ? rs_reg :
                    (rs_reg == '0) ? omrq_pkg::SLOT_W'(ring_n - 1'b1) : rs_reg - 1'b1;
    assign head_len = lengths_reg[head];

    always_comb
    begin
        slots_next    = slots_reg;
        bsize_next    = bsize_reg;
        ws_next       = ws_reg;
        rs_next       = rs_reg;
        wrap_next     = wrap_reg;
        open_len_next = open_len_reg;
        open_next     = open_reg;
        len_we        = 1'b0;
        len_wdata     = open_len_reg;
        cmd_valid     = 1'b0;
        cmd           = '0;
        cmd.op        = omrq_pkg::RES_NONE;
        cmd.kind      = omrq_pkg::KIND_STORED;
        cmd.wr_addr   = omrq_pkg::store_addr(ws_reg, open_len_reg);
        cmd.wr_data   = data_byte;
        priority if (cfg_write)
        begin
            unique case (cfg_index)
                omrq_pkg::CFG_SLOTS: slots_next = cfg_data[omrq_pkg::CNT_W-1:0];
                omrq_pkg::CFG_BYTES: bsize_next = cfg_data;
                default:             slots_next = slots_reg;
            endcase
            ws_next       = '0;
            rs_next       = '0;
            wrap_next     = 1'b0;
            open_len_next = '0;
            open_next     = 1'b0;
        end
        else if (accept && operation == omrq_pkg::OP_PUSH)
        begin
            open_next = 1'b1;
            if (byte_valid && omrq_pkg::BSIZE_W'(open_len_reg) < cap)
            begin
                cmd_valid = 1'b1;
                cmd.wr_en = 1'b1;
                len_wdata = open_len_reg + 1'b1;
            end
            open_len_next = len_wdata;
            if (last_byte)
            begin
                len_we        = 1'b1;
                open_len_next = '0;
                open_next     = 1'b0;
                ws_next       = ring_inc(ws_reg, ring_n);
                if (ws_next == rs_reg)
                begin
                    rs_next   = ring_inc(rs_reg, ring_n);
                    wrap_next = 1'b1;
                end
                cmd_valid   = 1'b1;
                cmd.op      = omrq_pkg::RES_SINGLE;
                cmd.kind    = omrq_pkg::KIND_STORED;
                cmd.slot    = ws_reg;
                cmd.entries = ring_count(ws_next, rs_next, wrap_next, ring_n);
            end
        end
        else if (accept)
        begin
            cmd_valid = 1'b1;
            cmd.op    = omrq_pkg::RES_SINGLE;
            priority if (open_reg)
            begin
                cmd.kind    = omrq_pkg::KIND_BUSY;
                cmd.entries = ring_count(ws_reg, rs_reg, wrap_reg, ring_n);
            end
            else if (rs_reg == ws_reg && !wrap_reg)
            begin
                cmd.kind = omrq_pkg::KIND_EMPTY;
            end
            else
            begin
                if (rs_reg == ws_reg)
                begin
                    wrap_next = 1'b0;
                end
                else
                begin
                    rs_next = ring_inc(rs_reg, ring_n);
                end
                cmd.kind    = omrq_pkg::KIND_BYTE;
                cmd.slot    = head;
                cmd.len     = head_len;
                cmd.entries = ring_count(ws_reg, rs_next, wrap_next, ring_n);
                if (head_len != '0)
                begin
                    cmd.op = omrq_pkg::RES_STREAM;
                end
            end
        end
        else
        begin
            cmd_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg    <= omrq_pkg::CNT_W'(omrq_pkg::QUEUE_SLOTS);
            bsize_reg    <= omrq_pkg::BSIZE_W'(omrq_pkg::SLOT_BYTES);
            ws_reg       <= '0;
            rs_reg       <= '0;
            wrap_reg     <= 1'b0;
            open_len_reg <= '0;
            open_reg     <= 1'b0;
        end
        else
        begin
            slots_reg    <= slots_next;
            bsize_reg    <= bsize_next;
            ws_reg       <= ws_next;
            rs_reg       <= rs_next;
            wrap_reg     <= wrap_next;
            open_len_reg <= open_len_next;
            open_reg     <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            lengths_reg[ws_reg] <= len_wdata;
        end
    end

endmodule

FILE: rtl/omrq_cmd_queue.sv
module omrq_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  omrq_pkg::cmd_t in_cmd,
    output logic           in_ready,
    output logic           out_valid,
    output omrq_pkg::cmd_t out_cmd,
    input  logic           out_take
);

    omrq_pkg::cmd_t q_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           do_push;
    logic           do_pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = q_reg[rp_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_take && out_valid;

    always_comb
    begin
        wp_next  = do_push ? !wp_reg : wp_reg;
        rp_next  = do_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

FILE: rtl/omrq_back.sv
module omrq_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  omrq_pkg::cmd_t                cmd,
    output logic                          cmd_take,
    input  logic                          pop,
    output logic                          empty,
    output omrq_pkg::res_t                res
);

    logic [omrq_pkg::BYTE_W-1:0] store_reg [omrq_pkg::MEM_DEPTH];
    logic [omrq_pkg::BYTE_W-1:0] rd_q_reg;

    logic                        str_active_reg, str_active_next;
    logic [omrq_pkg::SLOT_W-1:0] str_slot_reg, str_slot_next;
    logic [omrq_pkg::LEN_W-1:0]  str_len_reg, str_len_next;
    logic [omrq_pkg::LEN_W-1:0]  str_idx_reg, str_idx_next;
    logic [omrq_pkg::CNT_W-1:0]  str_ent_reg, str_ent_next;

    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_mem_reg, s1_mem_next;
    omrq_pkg::res_t              s1_res_reg, s1_res_next;

    omrq_pkg::res_t              q_reg [omrq_pkg::RES_DEPTH];
    logic [omrq_pkg::RES_AW-1:0] q_wp_reg, q_rp_reg;
    logic [omrq_pkg::RES_CW-1:0] q_cnt_reg;

    logic                        space;
    logic                        mem_we;
    logic                        rd_en;
    logic [omrq_pkg::MEM_AW-1:0] rd_addr;
    logic                        str_last;
    logic                        q_pop;
    omrq_pkg::res_t              q_in;

    assign space = ({1'b0, q_cnt_reg} + (omrq_pkg::RES_CW + 1)'(s1_valid_reg))
                   < (omrq_pkg::RES_CW + 1)'(omrq_pkg::RES_DEPTH);
    assign str_last = (omrq_pkg::LEN_W'(str_idx_reg + 1'b1) == str_len_reg);
    assign rd_addr  = omrq_pkg::store_addr(str_slot_reg, str_idx_reg);
    assign mem_we   = cmd_take && cmd.wr_en;

    always_comb
    begin
        cmd_take        = 1'b0;
        rd_en           = 1'b0;
        str_active_next = str_active_reg;
        str_slot_next   = str_slot_reg;
        str_len_next    = str_len_reg;
        str_idx_next    = str_idx_reg;
        str_ent_next    = str_ent_reg;
        s1_valid_next   = 1'b0;
        s1_mem_next     = s1_mem_reg;
        s1_res_next     = s1_res_reg;
        priority if (str_active_reg)
        begin
            if (space)
            begin
                rd_en                  = 1'b1;
                s1_valid_next          = 1'b1;
                s1_mem_next            = 1'b1;
                s1_res_next.kind       = omrq_pkg::KIND_BYTE;
                s1_res_next.slot       = str_slot_reg;
                s1_res_next.data       = '0;
                s1_res_next.data_valid = 1'b1;
                s1_res_next.last       = str_last;
                s1_res_next.entries    = str_ent_reg;
                str_idx_next           = str_idx_reg + 1'b1;
                if (str_last)
                begin
                    str_active_next = 1'b0;
                end
            end
        end
        else if (cmd_valid)
        begin
            unique case (cmd.op)
                omrq_pkg::RES_NONE:
                begin
                    cmd_take = 1'b1;
                end
                omrq_pkg::RES_SINGLE:
                begin
                    if (space)
                    begin
                        cmd_take               = 1'b1;
                        s1_valid_next          = 1'b1;
                        s1_mem_next            = 1'b0;
                        s1_res_next.kind       = cmd.kind;
                        s1_res_next.slot       = cmd.slot;
                        s1_res_next.data       = '0;
                        s1_res_next.data_valid = 1'b0;
                        s1_res_next.last       = 1'b1;
                        s1_res_next.entries    = cmd.entries;
                    end
                end
                omrq_pkg::RES_STREAM:
                begin
                    cmd_take        = 1'b1;
                    str_active_next = 1'b1;
                    str_slot_next   = cmd.slot;
                    str_len_next    = cmd.len;
                    str_idx_next    = '0;
                    str_ent_next    = cmd.entries;
                end
                default:
                begin
                    cmd_take = 1'b1;
                end
            endcase
        end
        else
        begin
            cmd_take = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[cmd.wr_addr] <= cmd.wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= store_reg[rd_addr];
        end
    end

    always_comb
    begin
        q_in      = s1_res_reg;
        q_in.data = s1_mem_reg ? rd_q_reg : '0;
    end

    assign empty = (q_cnt_reg == '0);
    assign q_pop = pop && !empty;
    assign res   = q_reg[q_rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            str_active_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            q_wp_reg       <= '0;
            q_rp_reg       <= '0;
            q_cnt_reg      <= '0;
        end
        else
        begin
            str_active_reg <= str_active_next;
            s1_valid_reg   <= s1_valid_next;
            if (s1_valid_reg)
            begin
                q_wp_reg <= q_wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                q_rp_reg <= q_rp_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + omrq_pkg::RES_CW'(s1_valid_reg)
                         - omrq_pkg::RES_CW'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        str_slot_reg <= str_slot_next;
        str_len_reg  <= str_len_next;
        str_idx_reg  <= str_idx_next;
        str_ent_reg  <= str_ent_next;
        s1_mem_reg   <= s1_mem_next;
        s1_res_reg   <= s1_res_next;
        if (s1_valid_reg)
        begin
            q_reg[q_wp_reg] <= q_in;
        end
    end

endmodule

FILE: rtl/overwrite_message_ring_queue.sv
// Overwriting ring queue of byte messages.
// Input side: push/full. A push item (operation 0) carries one message byte;
// the item with last_byte set commits the message to the write slot. A
// dequeue item (operation 1) asks for the head message.
// Result side: empty/pop. Results appear in order: one "stored" item per
// commit, one "empty" or "busy" item per refused dequeue, or the head
// message as one item per byte (one item with out_byte_valid low for an
// empty message). last_result marks the final item of each input.
// Config: cfg_write/cfg_index/cfg_data, taken at once; any write empties the
// queue and drops the open message.
// Throughput: one push item per cycle while full is low. While the back
// end streams the bytes of a dequeue, the two-entry command queue holds
// at most two further commands, and full rises once it is full.
// Path: results pass the command queue, the back-end stage and the result
// queue; message bytes then follow one per cycle while it has space.
// When pop is held low, the four-entry result queue fills, the read stream
// pauses, then the command queue fills and full rises.
// Reset: pointers, open message and queues clear; registers return to 16
// slots of 64 bytes. The byte memory and slot lengths are not cleared.
module overwrite_message_ring_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           operation,
    input  logic [omrq_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           byte_valid,
    input  logic                           last_byte,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [omrq_pkg::BSIZE_W-1:0]   cfg_data,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     kind,
    output logic [omrq_pkg::SLOT_W-1:0]    slot_index,
    output logic [omrq_pkg::BYTE_W-1:0]    out_byte,
    output logic                           out_byte_valid,
    output logic                           last_result,
    output logic [omrq_pkg::CNT_W-1:0]     entries
);

    logic           f_cmd_valid;
    omrq_pkg::cmd_t f_cmd;
    logic           f_cmd_ready;
    logic           b_cmd_valid;
    omrq_pkg::cmd_t b_cmd;
    logic           b_cmd_take;
    omrq_pkg::res_t res;

    omrq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (f_cmd_valid),
        .cmd        (f_cmd),
        .cmd_ready  (f_cmd_ready)
    );

    omrq_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_cmd_valid),
        .in_cmd    (f_cmd),
        .in_ready  (f_cmd_ready),
        .out_valid (b_cmd_valid),
        .out_cmd   (b_cmd),
        .out_take  (b_cmd_take)
    );

    omrq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_cmd_valid),
        .cmd       (b_cmd),
        .cmd_take  (b_cmd_take),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign kind           = res.kind;
    assign slot_index     = res.slot;
    assign out_byte       = res.data;
    assign out_byte_valid = res.data_valid;
    assign last_result    = res.last;
    assign entries        = res.entries;

endmodule

FILE: rtl/omrq_checker.sv
module omrq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        empty,
    input logic [1:0]                  kind,
    input logic [omrq_pkg::SLOT_W-1:0] slot_index,
    input logic [omrq_pkg::BYTE_W-1:0] out_byte,
    input logic                        out_byte_valid,
    input logic                        last_result,
    input logic [omrq_pkg::CNT_W-1:0]  entries
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != omrq_pkg::KIND_BYTE) |-> (last_result && !out_byte_valid))
        else $error("non-byte item not a single final item");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == omrq_pkg::KIND_EMPTY) |-> (entries == '0 && slot_index == '0))
        else $error("empty answer with nonzero count or slot");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_byte_valid) |-> (out_byte == '0))
        else $error("out_byte set without out_byte_valid");

    a_stream_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == omrq_pkg::KIND_BYTE && !last_result) |=>
        (empty || (kind == omrq_pkg::KIND_BYTE && $stable(slot_index)
                   && $stable(entries))))
        else $error("message stream broken before its final byte");

endmodule

bind overwrite_message_ring_queue omrq_checker u_omrq_checker (.*);

FILE: test/omrq_reply_checker.sv
`timescale 1ns / 1ps

module omrq_reply_checker
    import omrq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               operation,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               byte_valid,
    input  logic               last_byte,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [BSIZE_W-1:0] cfg_data,
    input  logic               empty,
    input  logic               pop,
    input  logic [1:0]         kind,
    input  logic [SLOT_W-1:0]  slot_index,
    input  logic [BYTE_W-1:0]  out_byte,
    input  logic               out_byte_valid,
    input  logic               last_result,
    input  logic [CNT_W-1:0]   entries,
    output int                 mismatches,
    output int                 outstanding
);

    logic [CNT_W-1:0]   ring_slots_cfg;
    logic [BSIZE_W-1:0] slot_bytes_cfg;
    int                 wr_ptr;
    int                 rd_ptr;
    bit                 wrap;
    logic [BYTE_W-1:0]  byte_mem [MEM_DEPTH];
    int                 msg_len [QUEUE_SLOTS];
    int                 open_len;
    bit                 open_msg;
    res_t               replies [$];
    int                 fail_tally = 0;
    int                 waiting_cnt = 0;

    assign mismatches  = fail_tally;
    assign outstanding = waiting_cnt;

    function automatic int ring_n();
        int n;
        n = ring_slots_cfg;
        if (n < 1) n = 1;
        if (n > QUEUE_SLOTS) n = QUEUE_SLOTS;
        return n;
    endfunction

    function automatic int held_messages();
        int n;
        int d;
        n = ring_n();
        d = (wr_ptr + n - rd_ptr) % n;
        if (wrap)
        begin
            d = (d + 1) % n;
            if (d == 0) d = n;
        end
        return d;
    endfunction

    function automatic res_t make_reply(kind_t k, int slot, int data, bit dv, bit lst,
                                        int ent);
        res_t r;
        r.kind       = k;
        r.slot       = SLOT_W'(slot);
        r.data       = BYTE_W'(data);
        r.data_valid = dv;
        r.last       = lst;
        r.entries    = CNT_W'(ent);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        fail_tally++;
        $display("%0t: %s", $time, what);
    endtask

    task automatic clear_ring();
        wr_ptr   = 0;
        rd_ptr   = 0;
        wrap     = 0;
        open_len = 0;
        open_msg = 0;
    endtask

    task automatic predict_item(input logic op, input logic [BYTE_W-1:0] b,
                                input logic bv, input logic lst);
        int n;
        int cap;
        int slot;
        int head;
        int len;
        int ent;
        n = ring_n();
        if (op == OP_PUSH)
        begin
            cap = slot_bytes_cfg;
            if (cap < 1) cap = 1;
            if (cap > SLOT_BYTES) cap = SLOT_BYTES;
            cap = cap - 1;
            open_msg = 1;
            if (bv && open_len < cap)
            begin
                byte_mem[wr_ptr * SLOT_BYTES + open_len] = b;
                open_len++;
            end
            if (lst)
            begin
                slot          = wr_ptr;
                msg_len[slot] = open_len;
                open_len      = 0;
                open_msg      = 0;
                wr_ptr        = (wr_ptr + 1) % n;
                if (wr_ptr == rd_ptr)
                begin
                    rd_ptr = (rd_ptr + 1) % n;
                    wrap   = 1;
                end
                replies.push_back(make_reply(KIND_STORED, slot, 0, 0, 1, held_messages()));
            end
        end
        else if (open_msg)
            replies.push_back(make_reply(KIND_BUSY, 0, 0, 0, 1, held_messages()));
        else if (rd_ptr == wr_ptr && !wrap)
            replies.push_back(make_reply(KIND_EMPTY, 0, 0, 0, 1, 0));
        else
        begin
            head = wrap ? (rd_ptr + n - 1) % n : rd_ptr;
            len  = msg_len[head];
            if (len > SLOT_BYTES - 1) len = SLOT_BYTES - 1;
            if (rd_ptr == wr_ptr)
                wrap = 0;
            else
                rd_ptr = (rd_ptr + 1) % n;
            ent = held_messages();
            if (len == 0)
                replies.push_back(make_reply(KIND_BYTE, head, 0, 0, 1, ent));
            for (int i = 0; i < len; i++)
                replies.push_back(make_reply(KIND_BYTE, head, byte_mem[head * SLOT_BYTES + i],
                                             1, i + 1 == len, ent));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            ring_slots_cfg = CNT_W'(QUEUE_SLOTS);
            slot_bytes_cfg = BSIZE_W'(SLOT_BYTES);
            clear_ring();
            replies.delete();
            waiting_cnt = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got.kind       = kind_t'(kind);
                got.slot       = slot_index;
                got.data       = out_byte;
                got.data_valid = out_byte_valid;
                got.last       = last_result;
                got.entries    = entries;
                if (replies.size() == 0)
                    report_mismatch("result item with nothing pending");
                else
                begin
                    want = replies.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "want %0d/%0d/%02h/%0b/%0b/%0d got %0d/%0d/%02h/%0b/%0b/%0d",
                            want.kind, want.slot, want.data, want.data_valid, want.last,
                            want.entries, got.kind, got.slot, got.data, got.data_valid,
                            got.last, got.entries));
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_SLOTS)
                    ring_slots_cfg = cfg_data[CNT_W-1:0];
                else
                    slot_bytes_cfg = cfg_data;
                clear_ring();
            end
            if (push && !full)
                predict_item(operation, data_byte, byte_valid, last_byte);
            waiting_cnt = replies.size();
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import omrq_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic               operation;
    logic [BYTE_W-1:0]  data_byte;
    logic               byte_valid;
    logic               last_byte;
    logic               cfg_write;
    logic               cfg_index;
    logic [BSIZE_W-1:0] cfg_data;
    logic               empty;
    logic               pop;
    logic [1:0]         kind;
    logic [SLOT_W-1:0]  slot_index;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_byte_valid;
    logic               last_result;
    logic [CNT_W-1:0]   entries;
    int                 mismatches;
    int                 outstanding;
    int                 burst_left;

    logic [BSIZE_W-1:0] ring_cfg [8] = '{7'd2, 7'd1, 7'd16, 7'd0, 7'd31, 7'd98, 7'd4, 7'd3};
    logic [BSIZE_W-1:0] size_cfg [8] = '{7'd4, 7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd2, 7'd64};

    overwrite_message_ring_queue u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .last_byte      (last_byte),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .slot_index     (slot_index),
        .out_byte       (out_byte),
        .out_byte_valid (out_byte_valid),
        .last_result    (last_result),
        .entries        (entries)
    );

    omrq_reply_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .last_byte      (last_byte),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .slot_index     (slot_index),
        .out_byte       (out_byte),
        .out_byte_valid (out_byte_valid),
        .last_result    (last_result),
        .entries        (entries),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("overwrite_message_ring_queue verification failed");
        $finish;
    end

    // result side stall pattern
    initial
    begin
        int mode;
        int span;
        pop = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 48);
            for (int c = 0; c < span; c++)
            begin
                @(negedge clk);
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= (c % 16) >= 12;
                    default: pop <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    task automatic send_item(input logic op, input logic [BYTE_W-1:0] b, input logic bv,
                             input logic lst);
        int gap;
        @(negedge clk);
        push       <= 1'b1;
        operation  <= op;
        data_byte  <= b;
        byte_valid <= bv;
        last_byte  <= lst;
        @(posedge clk);
        while (full) @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic send_dequeue();
        send_item(OP_DEQ, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // hold the sender until every pending result is out
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [BSIZE_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int  random_count;
        int  phase;
        int  k;
        int  pick;
        int  cap;
        bit  paused;
        push       = 1'b0;
        operation  = OP_PUSH;
        data_byte  = '0;
        byte_valid = 1'b0;
        last_byte  = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_SLOTS;
        cfg_data   = '0;
        rst_n      = 1'b0;
        burst_left = $urandom_range(1, 10);
        cap        = SLOT_BYTES - 1;
        paused     = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // directed items at reset sizes
        send_dequeue();
        send_item(OP_PUSH, 8'h00, 1'b0, 1'b1);
        send_item(OP_PUSH, 8'h00, 1'b1, 1'b0);
        send_item(OP_PUSH, 8'hff, 1'b1, 1'b0);
        send_item(OP_PUSH, 8'ha5, 1'b0, 1'b0);
        send_item(OP_PUSH, 8'h5a, 1'b1, 1'b1);
        send_item(OP_PUSH, 8'h12, 1'b1, 1'b0);
        send_dequeue();
        send_item(OP_PUSH, 8'h34, 1'b1, 1'b1);
        repeat (4) send_dequeue();

        // register write drops an open message
        send_item(OP_PUSH, 8'h77, 1'b1, 1'b0);
        settle();
        write_reg(CFG_SLOTS, 7'd1);
        write_reg(CFG_BYTES, 7'd1);
        send_dequeue();
        send_item(OP_PUSH, 8'hc3, 1'b1, 1'b1);
        send_item(OP_PUSH, 8'h3c, 1'b1, 1'b1);
        send_dequeue();
        send_dequeue();

        // overflow of a three slot ring
        settle();
        write_reg(CFG_BYTES, 7'd3);
        write_reg(CFG_SLOTS, 7'd3);
        for (int i = 0; i < 4; i++)
            send_item(OP_PUSH, 8'(8'h40 + i), 1'b1, 1'b1);
        send_dequeue();

        random_count = 0;
        phase        = 0;
        while (random_count < 95)
        begin
            if (phase < 8 && random_count >= phase * 11)
            begin
                settle();
                write_reg(CFG_SLOTS, ring_cfg[phase]);
                write_reg(CFG_BYTES, size_cfg[phase]);
                cap = size_cfg[phase];
                if (cap < 1) cap = 1;
                if (cap > SLOT_BYTES) cap = SLOT_BYTES;
                cap = cap - 1;
                phase++;
            end
            if (!paused && random_count >= 55)
            begin
                settle();
                paused = 1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                k = ($urandom_range(0, 11) == 0) ? cap + $urandom_range(1, 3)
                                                 : $urandom_range(1, 5);
                for (int i = 0; i < k; i++)
                    send_item(OP_PUSH, 8'($urandom), $urandom_range(0, 5) != 0, i == k - 1);
                random_count += k;
            end
            else if (pick < 9)
            begin
                send_dequeue();
                random_count++;
            end
            else
            begin
                // dequeue in the middle of a message
                send_item(OP_PUSH, 8'($urandom), 1'b1, 1'b0);
                send_dequeue();
                send_item(OP_PUSH, 8'($urandom), 1'($urandom), 1'b1);
                random_count += 3;
            end
        end

        @(negedge clk);
        push <= 1'b0;
        wait (outstanding == 0);
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("overwrite_message_ring_queue verification clean");
        else
            $display("overwrite_message_ring_queue verification failed");
        $finish;
    end

endmodule
